@@ src/mctp_pkg.sv @@
// ----------------------------------------------------------------------------
// mctp_pkg
// Shared types and constants for the MIDI clock tracking PLL.
// ----------------------------------------------------------------------------
`default_nettype none

package mctp_pkg;

    // Command codes of an input request
    localparam logic [1:0] CMD_PULSE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_TIMER = 2'd3;

    // Run modes
    localparam logic [1:0] MODE_STOPPED  = 2'd0;
    localparam logic [1:0] MODE_STARTING = 2'd1;
    localparam logic [1:0] MODE_STARTED  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PLL_WEIGHT = 1'b0;
    localparam logic CFG_PHASE_GAIN = 1'b1;

    localparam int CFG_DATA_WIDTH     = 9;
    localparam int TIMESTAMP_WIDTH    = 16;
    localparam int TIME_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [8:0] WEIGHT_RESET = 9'd220;
    localparam logic [7:0] GAIN_RESET   = 8'd15;
    localparam logic [8:0] WEIGHT_FULL  = 9'd256;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic        tick;
        logic [15:0] interval_estimate;
    } t_out_item;

    // Classified request as it waits between front and back
    typedef struct packed {
        logic        is_pulse;
        logic        is_start;
        logic        is_stop;
        logic        is_timer;
        logic [15:0] timestamp;
    } t_queue_item;

endpackage

`default_nettype wire

@@ src/mctp_front.sv @@
// ----------------------------------------------------------------------------
// mctp_front
// Accepts input requests, classifies the command and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module mctp_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mctp_pkg::t_in_item    i_in_item,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output mctp_pkg::t_queue_item o_q_item,
    output logic                  o_q_valid,
    input  wire                   i_q_pop
);
    import mctp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR   = PW'(QUEUE_DEPTH - 1);

    t_queue_item   r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    t_queue_item   w_class;
    logic          w_push;
    logic          w_pop;

    // Classify the command into one flag per kind
    always_comb begin
        w_class           = '0;
        w_class.timestamp = i_in_item.timestamp;
        case (i_in_item.command)
            CMD_PULSE: w_class.is_pulse = 1'b1;
            CMD_START: w_class.is_start = 1'b1;
            CMD_STOP:  w_class.is_stop  = 1'b1;
            default:   w_class.is_timer = 1'b1;
        endcase
    end

    assign o_in_ready = (r_count != FULL_COUNT);
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ src/mctp_back.sv @@
// ----------------------------------------------------------------------------
// mctp_back
// Executes queued requests: tempo averaging and the tick generator.
// ----------------------------------------------------------------------------
`default_nettype none

module mctp_back #(
    parameter int TIME_WIDTH = mctp_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mctp_pkg::t_queue_item i_q_item,
    input  wire                   i_q_valid,
    output logic                  o_q_pop,
    input  wire [8:0]             i_pll_weight,
    input  wire [7:0]             i_phase_gain,
    output mctp_pkg::t_out_item   o_out_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready
);
    import mctp_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam logic [TW-1:0] TWO = TW'(2);

    logic [1:0]    r_mode, n_mode;
    logic [TW-1:0] r_last, n_last;
    logic [TW-1:0] r_smooth, n_smooth;
    logic [TW-1:0] r_countdown, n_countdown;
    logic [TW-1:0] r_ticks, n_ticks;
    logic [TW-1:0] r_pulses, n_pulses;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_item;

    logic          w_take;
    logic          w_tick;
    logic [TW+15:0] w_now_ext;
    logic [TW-1:0] w_now;
    logic [TW-1:0] w_diff;
    logic [8:0]    w_weight;
    logic [8:0]    w_weight_c;
    logic [TW+8:0] w_prod_old;
    logic [TW+8:0] w_prod_new;
    logic [TW+9:0] w_sum;
    logic [TW-1:0] w_avg;
    logic [TW-1:0] w_pulses_inc;
    logic [TW-1:0] w_ticks_inc;
    logic [TW:0]   w_pulses_p1;
    logic          w_resync;
    logic [TW-1:0] w_ticks_sync;
    logic [TW+7:0] w_prod_lag;
    logic [TW-1:0] w_lead;
    logic [TW+7:0] w_prod_lead;
    logic [TW+15:0] w_est_ext;

    assign w_take  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = w_take;

    // Bring the 16-bit timestamp to the internal time width
    assign w_now_ext = {{TW{1'b0}}, i_q_item.timestamp};
    assign w_now     = w_now_ext[TW-1:0];
    assign w_diff    = w_now - r_last;

    // Exponential average with the weight clamped to 256
    assign w_weight   = (i_pll_weight > WEIGHT_FULL) ? WEIGHT_FULL : i_pll_weight;
    assign w_weight_c = WEIGHT_FULL - w_weight;
    assign w_prod_old = r_smooth * w_weight;
    assign w_prod_new = w_diff * w_weight_c;
    assign w_sum      = {1'b0, w_prod_old} + {1'b0, w_prod_new};
    assign w_avg      = w_sum[TW+7:8];

    assign w_pulses_inc = r_pulses + 1'b1;
    assign w_ticks_inc  = r_ticks + 1'b1;
    assign w_pulses_p1  = {1'b0, r_pulses} + 1'b1;
    assign w_resync     = (w_ticks_inc < r_pulses) || ({1'b0, w_ticks_inc} > w_pulses_p1);
    assign w_ticks_sync = w_resync ? r_pulses : w_ticks_inc;

    // Phase nudges: pull in when lagging, stretch when leading
    assign w_prod_lag  = w_diff * i_phase_gain;
    assign w_lead      = r_smooth - w_diff;
    assign w_prod_lead = w_lead * i_phase_gain;

    always_comb begin
        n_mode      = r_mode;
        n_last      = r_last;
        n_smooth    = r_smooth;
        n_countdown = r_countdown;
        n_ticks     = r_ticks;
        n_pulses    = r_pulses;
        w_tick      = 1'b0;
        if (i_q_item.is_pulse) begin
            n_last   = w_now;
            n_pulses = w_pulses_inc;
            if (r_mode == MODE_STARTING) begin
                n_mode = MODE_STARTED;
            end else if (w_pulses_inc == TWO) begin
                n_smooth = w_diff;
            end else begin
                n_smooth = w_avg;
            end
        end else if (i_q_item.is_start) begin
            n_last      = '0;
            n_countdown = '0;
            n_ticks     = '0;
            n_pulses    = '0;
            n_mode      = MODE_STARTING;
        end else if (i_q_item.is_stop) begin
            n_mode = MODE_STOPPED;
        end else if (i_q_item.is_timer && r_mode == MODE_STARTED) begin
            if (r_countdown != '0) begin
                n_countdown = r_countdown - 1'b1;
            end else begin
                w_tick  = 1'b1;
                n_ticks = w_ticks_sync;
                if (w_ticks_sync <= r_pulses) begin
                    n_countdown = r_smooth - w_prod_lag[TW+7:8];
                end else if (r_smooth > w_diff) begin
                    n_countdown = r_smooth + w_prod_lead[TW+7:8];
                end else begin
                    n_countdown = r_smooth;
                end
            end
        end
    end

    assign w_est_ext = {16'b0, n_smooth};

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_item.tick              <= w_tick;
            r_out_item.interval_estimate <= w_est_ext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOPPED;
            r_last      <= '0;
            r_smooth    <= '0;
            r_countdown <= '0;
            r_ticks     <= '0;
            r_pulses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_mode      <= n_mode;
                r_last      <= n_last;
                r_smooth    <= n_smooth;
                r_countdown <= n_countdown;
                r_ticks     <= n_ticks;
                r_pulses    <= n_pulses;
            end
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_item  = r_out_item;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ src/midi_clock_tracking_pll.sv @@
// ----------------------------------------------------------------------------
// midi_clock_tracking_pll
// Tracks the tempo of an incoming MIDI clock and generates locked ticks.
// ----------------------------------------------------------------------------
// Each request carries a command (clock pulse, start, stop, timer tick) and a
// 16-bit timestamp, and yields exactly one result: a tick flag and the current
// smoothed pulse interval. The block sustains one request per clock cycle
// while the output side is ready; a request is written into the queue, and
// its result is registered at the output when the back end takes it. The
// back end updates its state as it takes a request, so the next request
// reads the updated state. A two-entry queue separates the front end from
// the back end, and lets new requests be accepted while a result waits.
// Configuration writes take effect in the next cycle and are expected only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_clock_tracking_pll #(
    parameter int TIME_WIDTH = mctp_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Input requests
    input  mctp_pkg::t_in_item  i_in_item,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    // Results
    output mctp_pkg::t_out_item o_out_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    // Configuration writes
    input  wire                 i_cfg_wr_en,
    input  wire                 i_cfg_index,
    input  wire [mctp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);
    import mctp_pkg::*;

    logic [8:0]  r_pll_weight, n_pll_weight;
    logic [7:0]  r_phase_gain, n_phase_gain;
    t_queue_item w_q_item;
    logic        w_q_valid;
    logic        w_q_pop;

    // Latch configuration registers on a write
    always_comb begin
        n_pll_weight = r_pll_weight;
        n_phase_gain = r_phase_gain;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PLL_WEIGHT: n_pll_weight = i_cfg_data;
                CFG_PHASE_GAIN: n_phase_gain = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pll_weight <= WEIGHT_RESET;
            r_phase_gain <= GAIN_RESET;
        end else begin
            r_pll_weight <= n_pll_weight;
            r_phase_gain <= n_phase_gain;
        end
    end

    // Front end: accept, classify and queue requests
    mctp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_q_item   (w_q_item),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop)
    );

    // Back end: update the tempo estimate and run the tick generator
    mctp_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_item     (w_q_item),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_pll_weight (r_pll_weight),
        .i_phase_gain (r_phase_gain),
        .o_out_item   (o_out_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule

`default_nettype wire
